// ===== rtl/core/rkd_pkg.sv =====
package rkd_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned TimeW    = 31;
  localparam int unsigned DragW    = 16;
  localparam int unsigned GravW    = 24;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MulW     = 33;
  localparam int unsigned ProdW    = 66;
  localparam int unsigned WideW    = 68;
  localparam int unsigned SaccW    = 36;
  localparam int unsigned RootW    = 64;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned NumState = 6;

  localparam logic [IdxW-1:0]  RegDrag = IdxW'(0);
  localparam logic [IdxW-1:0]  RegGrav = IdxW'(1);
  localparam logic [DragW-1:0] DragRst = DragW'(2903);
  localparam logic [GravW-1:0] GravRst = GravW'(642908);

  // Offset keeping the six-fold sum plus rounding nonnegative: 6 * 2^32, plus 3.
  localparam logic [SaccW-1:0] Div6Bias = SaccW'(64'h6_0000_0003);

  typedef logic signed [DataW-1:0] word_t;

  typedef struct packed {
    logic [NumState-1:0][DataW-1:0] st;
    logic [TimeW-1:0]               dt;
  } job_t;

  typedef struct packed {
    logic [NumState-1:0][DataW-1:0] st;
    logic                           ovf;
  } res_t;

  typedef struct packed {
    word_t val;
    logic  ovf;
  } sat_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_NEXT    = 16'h0002,
    S_SQ_MUL  = 16'h0004,
    S_SQ_ACC  = 16'h0008,
    S_SQRT    = 16'h0010,
    S_AM_MUL  = 16'h0020,
    S_AM_USE  = 16'h0040,
    S_ACC_MUL = 16'h0080,
    S_ACC_USE = 16'h0100,
    S_STG_MUL = 16'h0200,
    S_STG_USE = 16'h0400,
    S_DIV_LD  = 16'h0800,
    S_DIV     = 16'h1000,
    S_UPD_MUL = 16'h2000,
    S_UPD_USE = 16'h4000,
    S_OUT     = 16'h8000
  } eng_state_e;

  function automatic sat_t sat32(input logic signed [WideW-1:0] v);
    sat_t r;
    if (&v[WideW-1:DataW-1] || ~|v[WideW-1:DataW-1]) begin
      r.val = v[DataW-1:0];
      r.ovf = 1'b0;
    end else begin
      r.val = v[WideW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  // Rounds half up, then shifts right with floor.
  function automatic logic signed [WideW-1:0] rnd_shr(input logic signed [ProdW-1:0] p,
                                                      input int unsigned sh);
    logic signed [WideW-1:0] w;
    w = {{(WideW-ProdW){p[ProdW-1]}}, p};
    w = w + (WideW'(1) << (sh - 1));
    return w >>> sh;
  endfunction

  // Quotient of a value below 96 by six, as a multiply by a scaled reciprocal.
  function automatic logic [3:0] div6_digit(input logic [6:0] x);
    logic [12:0] p;
    p = 13'(x) * 13'd43;
    return p[11:8];
  endfunction

endpackage

// ===== rtl/core/rkd_if.sv =====
interface rkd_launch_if import rkd_pkg::*; ();
  logic             valid;
  logic             ready;
  word_t            start_pos_x;
  word_t            start_pos_y;
  word_t            start_pos_z;
  word_t            start_vel_x;
  word_t            start_vel_y;
  word_t            start_vel_z;
  logic [TimeW-1:0] flight_time;

  modport source(output valid, start_pos_x, start_pos_y, start_pos_z, start_vel_x,
                 start_vel_y, start_vel_z, flight_time, input ready);
  modport sink(input valid, start_pos_x, start_pos_y, start_pos_z, start_vel_x,
               start_vel_y, start_vel_z, flight_time, output ready);
endinterface

interface rkd_result_if import rkd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t end_pos_x;
  word_t end_pos_y;
  word_t end_pos_z;
  word_t end_vel_x;
  word_t end_vel_y;
  word_t end_vel_z;
  logic  overflow;

  modport source(output valid, end_pos_x, end_pos_y, end_pos_z, end_vel_x, end_vel_y,
                 end_vel_z, overflow, input ready);
  modport sink(input valid, end_pos_x, end_pos_y, end_pos_z, end_vel_x, end_vel_y,
               end_vel_z, overflow, output ready);
endinterface

interface rkd_cfg_if import rkd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IdxW-1:0]     index;
  logic [CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/rkd_front.sv =====
module rkd_front import rkd_pkg::*; #(
  parameter int unsigned GridPoints = 100
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rkd_launch_if.sink launch,
  output job_t       job_o,
  output logic       job_valid_o,
  input  logic       job_ready_i
);

  // The step is the flight time times a rounded-up reciprocal of GridPoints - 1, which is
  // exact for every 31-bit flight time.
  localparam int unsigned LogD      = $clog2(GridPoints - 1);
  localparam int unsigned Shift     = TimeW + LogD;
  localparam int unsigned RecW      = TimeW + 1;
  localparam int unsigned QProdW    = TimeW + RecW;
  localparam logic [63:0] RecipWide = ((64'd1 << Shift) / 64'(GridPoints - 1)) + 64'd1;
  localparam logic [RecW-1:0] Recip = RecW'(RecipWide);

  front_state_e state_q, state_d;
  logic [NumState-1:0][DataW-1:0] st_q;
  logic [TimeW-1:0]  num_q;
  logic [QProdW-1:0] quo_prod;
  logic              take;

  assign launch.ready = (state_q == F_IDLE);
  assign take         = launch.valid && launch.ready;
  assign quo_prod     = QProdW'(num_q) * QProdW'(Recip);
  assign job_valid_o  = (state_q == F_PUSH);
  assign job_o.st     = st_q;
  assign job_o.dt     = num_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (take) state_d = F_DIV;
      F_DIV:  state_d = F_PUSH;
      F_PUSH: if (job_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      st_q[0] <= launch.start_pos_x;
      st_q[1] <= launch.start_pos_y;
      st_q[2] <= launch.start_pos_z;
      st_q[3] <= launch.start_vel_x;
      st_q[4] <= launch.start_vel_y;
      st_q[5] <= launch.start_vel_z;
      num_q   <= launch.flight_time;
    end else if (state_q == F_DIV) begin
      num_q <= TimeW'(quo_prod >> Shift);
    end
  end

endmodule

// ===== rtl/core/rkd_queue.sv =====
module rkd_queue import rkd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output job_t pop_data_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop)  rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + PtrW'(1);
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== rtl/core/rkd_engine.sv =====
module rkd_engine import rkd_pkg::*; #(
  parameter int unsigned GridPoints = 100,
  parameter int unsigned FracBits   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  job_t         job_i,
  input  logic         job_valid_i,
  output logic         job_ready_o,
  rkd_cfg_if.sink      cfg,
  rkd_result_if.source res
);

  localparam int unsigned StepW = $clog2(GridPoints);
  localparam logic [StepW-1:0] LastStep = StepW'(GridPoints - 2);

  eng_state_e state_q, state_d;
  logic [DragW-1:0] drag_q;
  logic [GravW-1:0] grav_q;
  word_t            st_q   [NumState];
  word_t            tmp_q  [NumState];
  word_t            k_q    [NumState];
  logic signed [SaccW-1:0] sacc_q [NumState];
  logic [TimeW-1:0] dt_q;
  logic [RootW-1:0] ss_q, rad_q, root_q;
  logic [4:0]       it_q;
  logic [DataW-2:0] am_q;
  logic [SaccW-1:0] dnum_q, dq_q;
  logic [2:0]       rem_q;
  logic [3:0]       dcnt_q;
  word_t            avg_q;
  logic [2:0]       ax_q;
  logic [1:0]       stg_q;
  logic [StepW-1:0] step_q;
  logic             ovf_q;
  res_t             out_q;
  logic             out_valid_q;

  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod_q;
  logic [2:0]       vax;
  logic [RootW-1:0] bitv, trial, ss_sum;
  logic             root_ge;
  logic signed [WideW-1:0] shr_f, shr_h, grav_term;
  sat_t             am_s, acc_s, stg_s, upd_s, avg_s;
  logic [6:0]       dx;
  logic [3:0]       dqd;
  logic [6:0]       drem;
  logic [SaccW-1:0] qfull;
  logic             dbl, out_free, job_take;

  assign vax       = ax_q + 3'd3;
  assign ss_sum    = ss_q + prod_q[RootW-1:0];
  assign bitv      = {2'b01, {(RootW-2){1'b0}}} >> {it_q, 1'b0};
  assign trial     = root_q + bitv;
  assign root_ge   = (rad_q >= trial);
  assign shr_f     = rnd_shr(prod_q, FracBits);
  assign shr_h     = rnd_shr(prod_q, FracBits + 1);
  assign grav_term = (ax_q == 3'd1) ? WideW'(grav_q) : '0;
  assign am_s      = sat32(shr_f);
  assign acc_s     = sat32(-shr_f - grav_term);
  assign stg_s     = sat32(WideW'(st_q[ax_q]) + ((stg_q == 2'd2) ? shr_f : shr_h));
  assign upd_s     = sat32(WideW'(st_q[ax_q]) + shr_f);
  assign dx        = {rem_q, dnum_q[SaccW-1 -: 4]};
  assign dqd       = div6_digit(dx);
  assign drem      = dx - 7'(dqd) * 7'd6;
  assign qfull     = {dq_q[SaccW-5:0], dqd};
  assign avg_s     = sat32(WideW'(qfull) - (WideW'(1) << DataW));
  assign dbl       = (stg_q == 2'd1) || (stg_q == 2'd2);
  assign out_free  = !out_valid_q || res.ready;
  assign job_ready_o = (state_q == S_IDLE);
  assign job_take  = job_valid_i && job_ready_o;
  assign cfg.ready = 1'b1;

  assign res.valid     = out_valid_q;
  assign res.end_pos_x = out_q.st[0];
  assign res.end_pos_y = out_q.st[1];
  assign res.end_pos_z = out_q.st[2];
  assign res.end_vel_x = out_q.st[3];
  assign res.end_vel_y = out_q.st[4];
  assign res.end_vel_z = out_q.st[5];
  assign res.overflow  = out_q.ovf;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQ_MUL: begin
        mul_a = MulW'(tmp_q[vax]);
        mul_b = MulW'(tmp_q[vax]);
      end
      S_AM_MUL: begin
        mul_a = MulW'(drag_q);
        mul_b = MulW'(root_q[DataW-1:0]);
      end
      S_ACC_MUL: begin
        mul_a = MulW'(am_q);
        mul_b = MulW'(tmp_q[vax]);
      end
      S_STG_MUL: begin
        mul_a = MulW'(dt_q);
        mul_b = MulW'(k_q[ax_q]);
      end
      S_UPD_MUL: begin
        mul_a = MulW'(dt_q);
        mul_b = MulW'(avg_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (job_take) state_d = S_NEXT;
      S_NEXT:    state_d = S_SQ_MUL;
      S_SQ_MUL:  state_d = S_SQ_ACC;
      S_SQ_ACC:  state_d = (ax_q == 3'd2) ? S_SQRT : S_SQ_MUL;
      S_SQRT:    if (it_q == 5'd31) state_d = S_AM_MUL;
      S_AM_MUL:  state_d = S_AM_USE;
      S_AM_USE:  state_d = S_ACC_MUL;
      S_ACC_MUL: state_d = S_ACC_USE;
      S_ACC_USE: begin
        if (ax_q != 3'd2) state_d = S_ACC_MUL;
        else state_d = (stg_q == 2'd3) ? S_DIV_LD : S_STG_MUL;
      end
      S_STG_MUL: state_d = S_STG_USE;
      S_STG_USE: state_d = (ax_q == 3'd5) ? S_SQ_MUL : S_STG_MUL;
      S_DIV_LD:  state_d = S_DIV;
      S_DIV:     if (dcnt_q == 4'd8) state_d = S_UPD_MUL;
      S_UPD_MUL: state_d = S_UPD_USE;
      S_UPD_USE: begin
        if (ax_q != 3'd5) state_d = S_DIV_LD;
        else state_d = (step_q == LastStep) ? S_OUT : S_NEXT;
      end
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      drag_q      <= DragRst;
      grav_q      <= GravRst;
      out_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
      ax_q        <= '0;
      stg_q       <= '0;
      step_q      <= '0;
      it_q        <= '0;
      dcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg.valid) begin
        priority case (cfg.index)
          RegDrag: drag_q <= cfg.data[DragW-1:0];
          RegGrav: grav_q <= cfg.data[GravW-1:0];
          default: ;
        endcase
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_take) begin
            ovf_q  <= 1'b0;
            step_q <= '0;
          end
        end
        S_NEXT: begin
          ax_q  <= '0;
          stg_q <= '0;
        end
        S_SQ_ACC: begin
          if (ax_q == 3'd2) it_q <= '0;
          else ax_q <= ax_q + 3'd1;
        end
        S_SQRT: it_q <= it_q + 5'd1;
        S_AM_USE: begin
          ax_q  <= '0;
          ovf_q <= ovf_q | am_s.ovf;
        end
        S_ACC_USE: begin
          ovf_q <= ovf_q | acc_s.ovf;
          ax_q  <= (ax_q == 3'd2) ? 3'd0 : ax_q + 3'd1;
        end
        S_STG_USE: begin
          ovf_q <= ovf_q | stg_s.ovf;
          if (ax_q == 3'd5) begin
            ax_q  <= '0;
            stg_q <= stg_q + 2'd1;
          end else begin
            ax_q <= ax_q + 3'd1;
          end
        end
        S_DIV_LD: dcnt_q <= '0;
        S_DIV: begin
          dcnt_q <= dcnt_q + 4'd1;
          if (dcnt_q == 4'd8) ovf_q <= ovf_q | avg_s.ovf;
        end
        S_UPD_USE: begin
          ovf_q <= ovf_q | upd_s.ovf;
          ax_q  <= (ax_q == 3'd5) ? 3'd0 : ax_q + 3'd1;
          if (ax_q == 3'd5) step_q <= step_q + StepW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: begin
        if (job_take) begin
          for (int i = 0; i < NumState; i++) st_q[i] <= job_i.st[i];
          dt_q <= job_i.dt;
        end
      end
      S_NEXT: begin
        for (int i = 0; i < NumState; i++) begin
          tmp_q[i]  <= st_q[i];
          sacc_q[i] <= '0;
        end
        ss_q <= '0;
      end
      S_SQ_ACC: begin
        ss_q <= ss_sum;
        if (ax_q == 3'd2) begin
          rad_q  <= ss_sum;
          root_q <= '0;
        end
      end
      S_SQRT: begin
        if (root_ge) begin
          rad_q  <= rad_q - trial;
          root_q <= (root_q >> 1) + bitv;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      S_AM_USE: am_q <= am_s.val[DataW-2:0];
      S_ACC_USE: begin
        k_q[ax_q]    <= tmp_q[vax];
        k_q[vax]     <= acc_s.val;
        sacc_q[ax_q] <= sacc_q[ax_q] + (SaccW'(tmp_q[vax]) <<< (dbl ? 1 : 0));
        sacc_q[vax]  <= sacc_q[vax] + (SaccW'(acc_s.val) <<< (dbl ? 1 : 0));
        if (ax_q == 3'd2) ss_q <= '0;
      end
      S_STG_USE: begin
        tmp_q[ax_q] <= stg_s.val;
        ss_q        <= '0;
      end
      S_DIV_LD: begin
        dnum_q <= SaccW'(sacc_q[ax_q]) + Div6Bias;
        rem_q  <= '0;
        dq_q   <= '0;
      end
      S_DIV: begin
        dnum_q <= dnum_q << 4;
        rem_q  <= drem[2:0];
        dq_q   <= qfull;
        if (dcnt_q == 4'd8) avg_q <= avg_s.val;
      end
      S_UPD_USE: st_q[ax_q] <= upd_s.val;
      S_OUT: begin
        if (out_free) begin
          for (int i = 0; i < NumState; i++) out_q.st[i] <= st_q[i];
          out_q.ovf <= ovf_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/rk4_drag_trajectory.sv =====
// Channel   Role    Moves
// launch_i  sink    start position, start velocity and flight time of one launch
// result_o  source  end position, end velocity and overflow flag of one launch
// cfg_i     sink    register index and write data
//
// The front takes a launch and scales the flight time into a step in its divide state.
// The engine then flies one launch at a time in GRID_POINTS - 1 RK4 steps; each step
// is four derivative passes, each bound by the square root, on one multiplier.
// A two-entry queue lets the front accept while the engine works, and the result
// register lets the engine start the next launch while a result waits to be taken.
// Reset clears all control state and restores both registers to their defaults.
module rk4_drag_trajectory import rkd_pkg::*; #(
  parameter int unsigned GRID_POINTS = 100,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rkd_launch_if.sink   launch_i,
  rkd_result_if.source result_o,
  rkd_cfg_if.sink      cfg_i
);

  job_t front_job, eng_job;
  logic front_valid, front_ready, eng_valid, eng_ready;

  rkd_front #(
    .GridPoints(GRID_POINTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .launch     (launch_i),
    .job_o      (front_job),
    .job_valid_o(front_valid),
    .job_ready_i(front_ready)
  );

  rkd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_data_i (front_job),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .pop_data_o  (eng_job),
    .pop_valid_o (eng_valid),
    .pop_ready_i (eng_ready)
  );

  rkd_engine #(
    .GridPoints(GRID_POINTS),
    .FracBits  (FRAC_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (eng_job),
    .job_valid_i(eng_valid),
    .job_ready_o(eng_ready),
    .cfg        (cfg_i),
    .res        (result_o)
  );

endmodule

// ===== rtl/core/rkd_checker.sv =====
module rkd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic [192:0] out_data_i
);

  logic [2:0] outst_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (in_acc && !out_acc) begin
      outst_q <= outst_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      outst_q <= outst_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result payload changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> outst_q != 3'd0)
    else $error("result delivered without an outstanding launch");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= 3'd5)
    else $error("more launches in flight than the block can hold");

endmodule

bind rk4_drag_trajectory rkd_checker u_rkd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (launch_i.valid),
  .in_ready_i (launch_i.ready),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_data_i ({result_o.end_pos_x, result_o.end_pos_y, result_o.end_pos_z,
                result_o.end_vel_x, result_o.end_vel_y, result_o.end_vel_z,
                result_o.overflow})
);

// ===== bench/tb_top.sv =====
module tb_top;
  import rkd_pkg::*;

  localparam int unsigned Grid      = 100;
  localparam int unsigned Frac      = 16;
  localparam int unsigned HoldLen   = 150000;
  localparam int unsigned StallMax  = 400000;
  localparam int unsigned PhaseLen  = 30;
  localparam logic [IdxW-1:0] RegUnused = IdxW'(2);

  typedef struct packed {
    logic [NumState-1:0][DataW-1:0] st;
    logic [TimeW-1:0]               ft;
  } launch_t;

  typedef struct packed {
    logic [NumState-1:0][DataW-1:0] st;
    logic                           ovf;
  } flight_t;

  typedef struct packed {
    launch_t l;
    logic    unchanged;
  } row_t;

  logic clk_i;
  logic rst_ni;

  rkd_launch_if launch ();
  rkd_result_if result ();
  rkd_cfg_if    cfg ();

  rk4_drag_trajectory #(
    .GRID_POINTS(Grid),
    .FRAC_BITS  (Frac)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .launch_i(launch),
    .result_o(result),
    .cfg_i   (cfg)
  );

  longint  drag_r;
  longint  grav_r;
  logic    sat_seen;
  flight_t end_state_q[$];
  int      mismatches;
  int      landed;
  int      saturated;
  int      stall_cnt;
  bit      quiet;
  bit      hold_req;
  row_t    plan[12];

  initial begin
    clk_i = 1'b0;
    forever begin
      #4 clk_i = 1'b1;
      #4 clk_i = 1'b0;
    end
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint mul_rnd(longint a, longint b, int unsigned sh);
    longint p;
    p = a * b + (longint'(1) << (sh - 1));
    return p >>> sh;
  endfunction

  function automatic longint floor_div6(longint x);
    if (x >= 0) return x / 6;
    return -1 - ((-(x + 1)) / 6);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void slope(input longint s[6], output longint k[6]);
    logic [63:0] ss;
    longint      am;
    longint      a;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      k[i] = s[3+i];
      ss = ss + 64'(s[3+i] * s[3+i]);
    end
    am = clamp32(mul_rnd(drag_r, longint'(int_sqrt(ss)), Frac));
    for (int i = 0; i < 3; i++) begin
      a = -mul_rnd(am, s[3+i], Frac);
      if (i == 1) a = a - grav_r;
      k[3+i] = clamp32(a);
    end
  endfunction

  function automatic flight_t fly(launch_t l);
    longint  s[6];
    longint  t[6];
    longint  k1[6];
    longint  k2[6];
    longint  k3[6];
    longint  k4[6];
    longint  dt;
    longint  sum;
    flight_t f;
    sat_seen = 1'b0;
    for (int i = 0; i < 6; i++) s[i] = longint'($signed(l.st[i]));
    dt = longint'(l.ft) / (Grid - 1);
    for (int n = 0; n < Grid - 1; n++) begin
      slope(s, k1);
      for (int i = 0; i < 6; i++) t[i] = clamp32(s[i] + mul_rnd(dt, k1[i], Frac + 1));
      slope(t, k2);
      for (int i = 0; i < 6; i++) t[i] = clamp32(s[i] + mul_rnd(dt, k2[i], Frac + 1));
      slope(t, k3);
      for (int i = 0; i < 6; i++) t[i] = clamp32(s[i] + mul_rnd(dt, k3[i], Frac));
      slope(t, k4);
      for (int i = 0; i < 6; i++) begin
        sum = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
        s[i] = clamp32(s[i] + mul_rnd(dt, clamp32(floor_div6(sum + 3)), Frac));
      end
    end
    for (int i = 0; i < 6; i++) f.st[i] = s[i][31:0];
    f.ovf = sat_seen;
    return f;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
    return $urandom_range(1, 4);
  endfunction

  task automatic offer_launch(input launch_t l, input bit unchanged);
    int      gap;
    flight_t f;
    gap = 0;
    if (!quiet && $urandom_range(0, 2) == 0) gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      launch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    launch.start_pos_x = l.st[0];
    launch.start_pos_y = l.st[1];
    launch.start_pos_z = l.st[2];
    launch.start_vel_x = l.st[3];
    launch.start_vel_y = l.st[4];
    launch.start_vel_z = l.st[5];
    launch.flight_time = l.ft;
    launch.valid       = 1'b1;
    do @(posedge clk_i); while (!launch.ready);
    if (unchanged) begin
      f.st  = l.st;
      f.ovf = 1'b0;
    end else begin
      f = fly(l);
    end
    end_state_q.push_back(f);
  endtask

  task automatic stop_offering();
    @(negedge clk_i);
    launch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = d;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      RegDrag: drag_r = longint'(d[DragW-1:0]);
      RegGrav: grav_r = longint'(d[GravW-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic drain();
    while (end_state_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic launch_t random_launch();
    launch_t l;
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m < 2) begin
      for (int i = 0; i < 6; i++) l.st[i] = $urandom();
      l.ft = TimeW'($urandom());
    end else begin
      for (int i = 0; i < 3; i++) l.st[i] = $urandom_range(0, 32'h07D0_0000) - 32'h03E8_0000;
      for (int i = 3; i < 6; i++) l.st[i] = $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
      l.ft = (m == 2) ? TimeW'($urandom_range(0, Grid - 2)) : TimeW'($urandom_range(0, 1310720));
    end
    return l;
  endfunction

  task automatic random_phase(input int cnt);
    for (int n = 0; n < cnt; n++) offer_launch(random_launch(), 1'b0);
    stop_offering();
  endtask

  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        result.ready = 1'b0;
        repeat (HoldLen) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        result.ready = 1'b0;
        repeat (idle_len() - 1) @(negedge clk_i);
      end else begin
        result.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    flight_t got;
    flight_t want;
    if (!rst_ni || (launch.valid && launch.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= StallMax) begin
      $display("Watchdog expired with %0d results outstanding.", end_state_q.size());
      $display("TEST FAILED");
      $finish;
    end
    if (rst_ni && result.valid && result.ready) begin
      got.st  = {result.end_vel_z, result.end_vel_y, result.end_vel_x,
                 result.end_pos_z, result.end_pos_y, result.end_pos_x};
      got.ovf = result.overflow;
      landed++;
      if (got.ovf) saturated++;
      if (end_state_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %h", got);
      end else begin
        want = end_state_q.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (got.st[i] !== want.st[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result %0d state word %0d: expected %h, got %h",
                       landed, i, want.st[i], got.st[i]);
          end
        end
        if (got.ovf !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d overflow: expected %b, got %b", landed, want.ovf, got.ovf);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    launch.valid = 1'b0;
    launch.start_pos_x = '0;
    launch.start_pos_y = '0;
    launch.start_pos_z = '0;
    launch.start_vel_x = '0;
    launch.start_vel_y = '0;
    launch.start_vel_z = '0;
    launch.flight_time = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    drag_r = longint'(DragRst);
    grav_r = longint'(GravRst);
    mismatches = 0;
    landed = 0;
    saturated = 0;
    stall_cnt = 0;
    quiet = 1'b0;
    hold_req = 1'b0;

    plan[0]  = '{l: '{st: '0, ft: '0}, unchanged: 1'b1};
    plan[1]  = '{l: '{st: {32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                     ft: '0}, unchanged: 1'b1};
    plan[2]  = '{l: '{st: {32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                     ft: TimeW'(Grid - 2)}, unchanged: 1'b1};
    plan[3]  = '{l: '{st: {32'h0064_0000, 32'hFF9C_0000, 32'h0032_0000, 32'h0, 32'h0, 32'h0},
                     ft: TimeW'(Grid - 2)}, unchanged: 1'b1};
    plan[4]  = '{l: '{st: '0, ft: TimeW'(Grid - 1)}, unchanged: 1'b0};
    plan[5]  = '{l: '{st: {32'h0, 32'h0032_0000, 32'h0032_0000, 32'h0, 32'h0, 32'h0},
                     ft: TimeW'(32'h0006_0000)}, unchanged: 1'b0};
    plan[6]  = '{l: '{st: {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0},
                     ft: TimeW'(32'h000A_0000)}, unchanged: 1'b0};
    plan[7]  = '{l: '{st: {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0},
                     ft: TimeW'(32'h7FFF_FFFF)}, unchanged: 1'b0};
    plan[8]  = '{l: '{st: {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                     ft: TimeW'(32'h0001_0000)}, unchanged: 1'b0};
    plan[9]  = '{l: '{st: {32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                     ft: TimeW'(32'h0001_0000)}, unchanged: 1'b0};
    plan[10] = '{l: '{st: {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 32'h0, 32'h0},
                     ft: TimeW'(32'h0000_FFFF)}, unchanged: 1'b0};
    plan[11] = '{l: '{st: {32'h0, 32'h0, 32'h0003_0000, 32'h0, 32'h0, 32'h0},
                     ft: TimeW'(32'h0014_0000)}, unchanged: 1'b0};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) offer_launch(plan[i].l, plan[i].unchanged);
    stop_offering();

    drain();
    write_reg(RegDrag, 32'h0);
    write_reg(RegGrav, 32'h0);
    random_phase(PhaseLen);

    drain();
    write_reg(RegDrag, 32'hFFFF_FFFF);
    write_reg(RegGrav, 32'hFFFF_FFFF);
    random_phase(PhaseLen);

    drain();
    write_reg(RegDrag, $urandom());
    write_reg(RegGrav, $urandom());
    write_reg(RegUnused, $urandom());
    random_phase(PhaseLen);

    drain();
    write_reg(RegDrag, {16'hA5A5, DragRst});
    write_reg(RegGrav, {8'h5A, GravRst});
    @(negedge clk_i);
    hold_req = 1'b1;
    random_phase(PhaseLen);

    drain();
    quiet = 1'b1;
    write_reg(RegDrag, $urandom_range(0, 8000));
    write_reg(RegGrav, $urandom_range(0, 1000000));
    random_phase(PhaseLen);

    drain();
    $display("Flew %0d launches over five register settings; %0d ended with saturation.",
             landed, saturated);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
